// ===== rtl/hmlp_pkg.sv =====
package hmlp_pkg;

    localparam int CONTEXT_COUNT = 32;
    localparam int CTX_BITS = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
    localparam int OFFSET_BITS = 16;

    localparam logic [7:0] TAG_MASK = 8'hFC;
    localparam logic [1:0] SIZE_MASK = 2'h3;
    localparam logic [OFFSET_BITS-1:0] CONTEXT_START = OFFSET_BITS'(8);

    localparam logic [7:0] CTL_USAGE_PAGE = 8'h04;
    localparam logic [7:0] CTL_USAGE = 8'h08;
    localparam logic [7:0] CTL_REPORT_SIZE = 8'h74;
    localparam logic [7:0] CTL_REPORT_ID = 8'h84;
    localparam logic [7:0] CTL_REPORT_COUNT = 8'h94;
    localparam logic [7:0] CTL_INPUT = 8'h80;
    localparam logic [7:0] CTL_FEATURE = 8'hB0;

    localparam logic [7:0] USE_BUTTON = 8'h09;
    localparam logic [7:0] USE_X = 8'h30;
    localparam logic [7:0] USE_Y = 8'h31;
    localparam logic [7:0] USE_WHEEL = 8'h38;

    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_X = 2'd1;
    localparam logic [1:0] KIND_Y = 2'd2;
    localparam logic [1:0] KIND_WHEEL = 2'd3;

    typedef struct packed {
        logic parse;
        logic place;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic place_needed;
    } status_t;

endpackage

// ===== rtl/hmlp_datapath.sv =====
module hmlp_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hmlp_pkg::cmd_t         cmd,
    output hmlp_pkg::status_t      status,
    input  logic [7:0]             desc_byte,
    input  logic [1:0]             out_kind,
    output logic                   out_found,
    output logic [7:0]             out_id,
    output logic [15:0]            out_offset,
    output logic [15:0]            out_size,
    output logic                   out_tagged
);

    localparam int CN = hmlp_pkg::CONTEXT_COUNT;
    localparam int CB = hmlp_pkg::CTX_BITS;
    localparam int OB = hmlp_pkg::OFFSET_BITS;

    logic [7:0]    ctx_id_reg [CN];
    logic [7:0]    ctx_id_next [CN];
    logic [OB-1:0] ctx_off_reg [CN];
    logic [OB-1:0] ctx_off_next [CN];
    logic [CB-1:0] cur_reg, cur_next;
    logic [2:0]    left_reg, left_next;
    logic [5:0]    tag_reg, tag_next;
    logic [1:0]    szc_reg, szc_next;
    logic [7:0]    rsize_reg, rsize_next;
    logic [7:0]    rcount_reg, rcount_next;
    logic [7:0]    use0_reg, use0_next;
    logic [7:0]    use1_reg, use1_next;
    logic          btn_reg, btn_next;
    logic          tagged_reg, tagged_next;
    logic [7:0]    lay_id_reg [4];
    logic [7:0]    lay_id_next [4];
    logic [15:0]   lay_off_reg [4];
    logic [15:0]   lay_off_next [4];
    logic [15:0]   lay_size_reg [4];
    logic [15:0]   lay_size_next [4];
    logic [3:0]    lay_found_reg, lay_found_next;
    logic          pend_reg, pend_next;
    logic [OB-1:0] base_reg, base_next;
    logic [15:0]   total_reg, total_next;
    logic [7:0]    pid_reg, pid_next;

    logic          run;
    logic [7:0]    data;
    logic [7:0]    ctl;
    logic [2:0]    full;
    logic          hit, free_hit;
    logic [CB-1:0] hit_idx, free_idx;
    logic [OB-1:0] off2;

    assign status.place_needed = pend_reg;

    always_comb
    begin
        full = (szc_reg == 2'd3) ? 3'd4 : {1'b0, szc_reg};
        run = 1'b0;
        data = 8'd0;
        ctl = 8'd0;
        left_next = left_reg;
        tag_next = tag_reg;
        szc_next = szc_reg;
        if (left_reg == 3'd0)
        begin
            tag_next = desc_byte[7:2];
            szc_next = desc_byte[1:0] & hmlp_pkg::SIZE_MASK;
            left_next = (szc_next == 2'd3) ? 3'd4 : {1'b0, szc_next};
            run = (szc_next == 2'd0);
            ctl = {tag_next, 2'b00} & hmlp_pkg::TAG_MASK;
        end
        else
        begin
            run = (left_reg == full);
            data = desc_byte;
            ctl = {tag_reg, 2'b00} & hmlp_pkg::TAG_MASK;
            left_next = left_reg - 3'd1;
        end
        hit = 1'b0;
        hit_idx = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int n = CN - 1; n >= 0; n--)
        begin
            if (ctx_id_reg[n] == data)
            begin
                hit = 1'b1;
                hit_idx = CB'(n);
            end
            if (ctx_id_reg[n] == 8'd0)
            begin
                free_hit = 1'b1;
                free_idx = CB'(n);
            end
        end
    end

    always_comb
    begin
        ctx_id_next = ctx_id_reg;
        ctx_off_next = ctx_off_reg;
        cur_next = cur_reg;
        rsize_next = rsize_reg;
        rcount_next = rcount_reg;
        use0_next = use0_reg;
        use1_next = use1_reg;
        btn_next = btn_reg;
        tagged_next = tagged_reg;
        lay_id_next = lay_id_reg;
        lay_off_next = lay_off_reg;
        lay_size_next = lay_size_reg;
        lay_found_next = lay_found_reg;
        pend_next = 1'b0;
        base_next = base_reg;
        total_next = total_reg;
        pid_next = pid_reg;
        off2 = base_reg + OB'(rsize_reg);
        if (cmd.parse && run)
        begin
            if (ctl == hmlp_pkg::CTL_REPORT_SIZE)
            begin
                rsize_next = data;
            end
            if (ctl == hmlp_pkg::CTL_REPORT_COUNT)
            begin
                rcount_next = data;
            end
            if (ctl == hmlp_pkg::CTL_REPORT_ID)
            begin
                tagged_next = 1'b1;
                if (hit)
                begin
                    cur_next = hit_idx;
                end
                else if (free_hit)
                begin
                    cur_next = free_idx;
                    ctx_id_next[free_idx] = data;
                    ctx_off_next[free_idx] = hmlp_pkg::CONTEXT_START;
                end
            end
            if ((ctl == hmlp_pkg::CTL_USAGE_PAGE || ctl == hmlp_pkg::CTL_USAGE)
                && szc_reg == 2'd1)
            begin
                if (data == hmlp_pkg::USE_BUTTON || data == hmlp_pkg::USE_WHEEL
                    || data == hmlp_pkg::USE_X || data == hmlp_pkg::USE_Y)
                begin
                    if (use0_reg == 8'd0)
                    begin
                        use0_next = data;
                    end
                    else
                    begin
                        use1_next = data;
                    end
                end
            end
            if (ctl == hmlp_pkg::CTL_INPUT || ctl == hmlp_pkg::CTL_FEATURE)
            begin
                pend_next = 1'b1;
                base_next = ctx_off_reg[cur_reg];
                pid_next = ctx_id_reg[cur_reg];
                total_next = rsize_reg * rcount_reg;
            end
        end
        if (cmd.place)
        begin
            if (!btn_reg && use0_reg == hmlp_pkg::USE_BUTTON)
            begin
                lay_id_next[0] = pid_reg;
                lay_off_next[0] = 16'(base_reg);
                lay_size_next[0] = total_reg;
                lay_found_next[0] = 1'b1;
                btn_next = 1'b1;
            end
            if (use0_reg == hmlp_pkg::USE_X)
            begin
                lay_id_next[1] = pid_reg;
                lay_off_next[1] = 16'(base_reg);
                lay_size_next[1] = {8'd0, rsize_reg};
                lay_found_next[1] = 1'b1;
            end
            else if (use0_reg == hmlp_pkg::USE_Y)
            begin
                lay_id_next[2] = pid_reg;
                lay_off_next[2] = 16'(base_reg);
                lay_size_next[2] = {8'd0, rsize_reg};
                lay_found_next[2] = 1'b1;
            end
            if (use1_reg == hmlp_pkg::USE_X)
            begin
                lay_id_next[1] = pid_reg;
                lay_off_next[1] = 16'(off2);
                lay_size_next[1] = {8'd0, rsize_reg};
                lay_found_next[1] = 1'b1;
            end
            else if (use1_reg == hmlp_pkg::USE_Y)
            begin
                lay_id_next[2] = pid_reg;
                lay_off_next[2] = 16'(off2);
                lay_size_next[2] = {8'd0, rsize_reg};
                lay_found_next[2] = 1'b1;
            end
            if (use0_reg == hmlp_pkg::USE_WHEEL)
            begin
                lay_id_next[3] = pid_reg;
                lay_off_next[3] = 16'(base_reg);
                lay_size_next[3] = total_reg;
                lay_found_next[3] = 1'b1;
            end
            use0_next = 8'd0;
            use1_next = 8'd0;
            ctx_off_next[cur_reg] = base_reg + OB'(total_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < CN; n++)
            begin
                ctx_id_reg[n] <= '0;
                ctx_off_reg[n] <= '0;
            end
            for (int k = 0; k < 4; k++)
            begin
                lay_id_reg[k] <= '0;
                lay_off_reg[k] <= '0;
                lay_size_reg[k] <= '0;
            end
            cur_reg <= '0;
            left_reg <= '0;
            tag_reg <= '0;
            szc_reg <= '0;
            rsize_reg <= '0;
            rcount_reg <= '0;
            use0_reg <= '0;
            use1_reg <= '0;
            btn_reg <= 1'b0;
            tagged_reg <= 1'b0;
            lay_found_reg <= '0;
            pend_reg <= 1'b0;
            base_reg <= '0;
            total_reg <= '0;
            pid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int n = 0; n < CN; n++)
            begin
                ctx_id_reg[n] <= '0;
                ctx_off_reg[n] <= '0;
            end
            for (int k = 0; k < 4; k++)
            begin
                lay_id_reg[k] <= '0;
                lay_off_reg[k] <= '0;
                lay_size_reg[k] <= '0;
            end
            cur_reg <= '0;
            left_reg <= '0;
            tag_reg <= '0;
            szc_reg <= '0;
            rsize_reg <= '0;
            rcount_reg <= '0;
            use0_reg <= '0;
            use1_reg <= '0;
            btn_reg <= 1'b0;
            tagged_reg <= 1'b0;
            lay_found_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ctx_id_reg <= ctx_id_next;
            ctx_off_reg <= ctx_off_next;
            lay_id_reg <= lay_id_next;
            lay_off_reg <= lay_off_next;
            lay_size_reg <= lay_size_next;
            cur_reg <= cur_next;
            rsize_reg <= rsize_next;
            rcount_reg <= rcount_next;
            use0_reg <= use0_next;
            use1_reg <= use1_next;
            btn_reg <= btn_next;
            tagged_reg <= tagged_next;
            lay_found_reg <= lay_found_next;
            pend_reg <= pend_next;
            base_reg <= base_next;
            total_reg <= total_next;
            pid_reg <= pid_next;
            if (cmd.parse)
            begin
                left_reg <= left_next;
                tag_reg <= tag_next;
                szc_reg <= szc_next;
            end
        end
    end

    assign out_found = lay_found_reg[out_kind];
    assign out_id = lay_id_reg[out_kind];
    assign out_offset = lay_off_reg[out_kind];
    assign out_size = lay_size_reg[out_kind];
    assign out_tagged = tagged_reg;

endmodule

// ===== rtl/hmlp_control.sv =====
module hmlp_control
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                in_last,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          out_kind,
    output hmlp_pkg::cmd_t      cmd,
    input  hmlp_pkg::status_t   status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PLACE = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic [1:0] kind_reg, kind_next;
    logic       take;

    assign in_stall = (state_reg != ST_IDLE);
    assign take = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_kind = kind_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        kind_next = kind_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.parse = 1'b1;
                    fin_next = in_last;
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place = status.place_needed;
                kind_next = hmlp_pkg::KIND_BUTTON;
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    kind_next = kind_reg + 2'd1;
                    if (kind_reg == hmlp_pkg::KIND_WHEEL)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg <= 1'b0;
            kind_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            kind_reg <= kind_next;
        end
    end

endmodule

// ===== rtl/hid_mouse_layout_parser.sv =====
// Channel  | Handshake           | Payload
// in       | in_valid, in_stall  | desc_byte, last_byte
// out      | out_valid, out_stall| field_kind, found, report_id, bit_offset, field_bits,
//          |                     | id_tagged, last
// Each byte passes ST_IDLE, which decodes the item and matches the report ID against
// all contexts in parallel, then ST_PLACE, which places pending usages and advances
// the offset. A final byte then yields four transfers, one per cycle when not stalled,
// after which ST_CLEAR resets all but base_reg, total_reg and pid_reg. Reset is
// asynchronous and clears all state. While results are pending the input is stalled.
module hid_mouse_layout_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  desc_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  field_kind,
    output logic        found,
    output logic [7:0]  report_id,
    output logic [15:0] bit_offset,
    output logic [15:0] field_bits,
    output logic        id_tagged,
    output logic        last
);

    hmlp_pkg::cmd_t    cmd;
    hmlp_pkg::status_t status;

    hmlp_control u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_last(last_byte),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .out_kind(field_kind),
        .cmd(cmd),
        .status(status)
    );

    hmlp_datapath u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .desc_byte(desc_byte),
        .out_kind(field_kind),
        .out_found(found),
        .out_id(report_id),
        .out_offset(bit_offset),
        .out_size(field_bits),
        .out_tagged(id_tagged)
    );

    assign last = (field_kind == hmlp_pkg::KIND_WHEEL);

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during output");
    a_kind_adv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid
            && field_kind == $past(field_kind) + 2'd1) else $error("kind order");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.parse, cmd.place, cmd.clear})) else $error("command clash");

endmodule
